/* hdl/bundle_header_checker_macros.svh */
// Assertion macros for the bundle header checker assertion file, bhc_checker.sv.
`ifndef BUNDLE_HEADER_CHECKER_MACROS_SVH
`define BUNDLE_HEADER_CHECKER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while in reset
`define BHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bundle header checker: assertion failed");

// Next-cycle implication, clocked on clk_i, off while in reset
`define BHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bundle header checker: assertion failed");

`endif

/* hdl/bhc_pkg.sv */
// Shared types, constants and byte classifiers for the bundle header checker.
`default_nettype none

package bhc_pkg;

  // Default parameter values
  localparam int unsigned PREFIX_LIMIT_DEF       = 512;
  localparam int unsigned MAX_VERSION_LEN_DEF    = 48;
  localparam int unsigned MAX_GENERATION_LEN_DEF = 32;

  // Fixed header geometry
  localparam int unsigned MIN_PREFIX   = 32;
  localparam int unsigned TAIL_LEN     = 20;
  localparam int unsigned MAGIC_LEN    = 8;
  localparam int unsigned FORMAT_END   = 11;
  localparam int unsigned SIZE_BYTES   = 8;
  localparam int unsigned CBLK_OFFSET  = 8;
  localparam int unsigned UBLK_OFFSET  = 12;
  localparam logic [31:0] FMT_MIN      = 32'd6;
  localparam logic [31:0] FMT_MAX      = 32'd8;
  localparam logic [19:0] NUM_MAX      = 20'd65535;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // File signature, byte 0 first
  localparam logic [7:0] MAGIC [MAGIC_LEN] = '{
    8'h55, 8'h6e, 8'h69, 8'h74, 8'h79, 8'h46, 8'h53, 8'h00
  };

  // Verdict codes
  typedef enum logic [2:0] {
    ST_RESOLVED   = 3'd0,
    ST_SHORT      = 3'd1,
    ST_MAGIC      = 3'd2,
    ST_FORMAT     = 3'd3,
    ST_GEN        = 3'd4,
    ST_VERSION    = 3'd5,
    ST_TAIL_SHORT = 3'd6,
    ST_GEOMETRY   = 3'd7
  } status_e;

  // Channel letter codes
  typedef enum logic [2:0] {
    CHAN_A = 3'd0,
    CHAN_B = 3'd1,
    CHAN_C = 3'd2,
    CHAN_F = 3'd3,
    CHAN_P = 3'd4,
    CHAN_X = 3'd5
  } chan_e;

  // Parse phase, one-hot
  typedef enum logic [7:0] {
    PH_MAGIC  = 8'b0000_0001,
    PH_FORMAT = 8'b0000_0010,
    PH_GEN    = 8'b0000_0100,
    PH_MAJOR  = 8'b0000_1000,
    PH_MINOR  = 8'b0001_0000,
    PH_PATCH  = 8'b0010_0000,
    PH_CHNUM  = 8'b0100_0000,
    PH_TAIL   = 8'b1000_0000
  } phase_e;

  // Verdict; the first member lands in the top bits of the packed word
  typedef struct packed {
    logic [15:0] chan_num;
    chan_e       channel_code;
    logic [15:0] patch_number;
    logic [15:0] minor_number;
    logic [15:0] major_number;
    logic [63:0] decl_size;
    logic [31:0] fmt_ver;
    status_e     status;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

  // Generation string characters: alphanumerics, dot, underscore, hyphen
  function automatic logic gen_char_ok(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
           (b >= 8'h61 && b <= 8'h7a) || b == 8'h2e || b == 8'h5f || b == 8'h2d;
  endfunction

  function automatic logic is_chan_letter(input logic [7:0] b);
    return b == 8'h61 || b == 8'h62 || b == 8'h63 ||
           b == 8'h66 || b == 8'h70 || b == 8'h78;
  endfunction

  function automatic chan_e chan_code(input logic [7:0] b);
    chan_e c;
    unique case (b)
      8'h61:   c = CHAN_A;
      8'h62:   c = CHAN_B;
      8'h63:   c = CHAN_C;
      8'h66:   c = CHAN_F;
      8'h70:   c = CHAN_P;
      default: c = CHAN_X;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/bhc_parser.sv */
// Byte-wise header parser: parse state registers and verdict logic.
`default_nettype none

module bhc_parser #(
  parameter int unsigned PREFIX_LIMIT       = bhc_pkg::PREFIX_LIMIT_DEF,
  parameter int unsigned MAX_VERSION_LEN    = bhc_pkg::MAX_VERSION_LEN_DEF,
  parameter int unsigned MAX_GENERATION_LEN = bhc_pkg::MAX_GENERATION_LEN_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,       // process one byte this cycle
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  input  wire logic [63:0]      file_len_i,
  output bhc_pkg::result_t      result_o      // verdict, valid with step_i & last_i
);
  import bhc_pkg::*;

  localparam int unsigned CountW = $clog2(PREFIX_LIMIT + 1);
  localparam int unsigned LenMax = (MAX_VERSION_LEN > MAX_GENERATION_LEN) ?
                                   MAX_VERSION_LEN : MAX_GENERATION_LEN;
  localparam int unsigned LenW   = $clog2(LenMax + 1);

  typedef struct packed {
    logic [CountW-1:0] count;
    phase_e            phase;
    logic [LenW-1:0]   len;
    status_e           first_err;
    logic              err;
    logic [31:0]       fmt;
    logic [CountW-1:0] tail;
    logic [63:0]       size;
    logic              have;       // current number has a digit
    logic [15:0]       acc;
    logic [15:0]       major;
    logic [15:0]       minor;
    logic [15:0]       patch;
    logic [15:0]       chnum;
    chan_e             chan;
    logic              blk_bad;
  } pstate_t;

  localparam pstate_t PST_RESET = '{
    count: '0, phase: PH_MAGIC, len: '0, first_err: ST_RESOLVED, err: 1'b0,
    fmt: '0, tail: '0, size: '0, have: 1'b0, acc: '0, major: '0, minor: '0,
    patch: '0, chnum: '0, chan: CHAN_A, blk_bad: 1'b0
  };

  pstate_t           st_q, st_d, upd;
  logic [CountW-1:0] pos;
  logic [CountW-1:0] tail_off;
  logic [31:0]       fmt_shift;
  logic [19:0]       num_next;
  logic              is_digit;
  logic              short_prefix;
  logic              tail_short;
  logic              bad_geom;
  status_e           status;

  assign pos       = st_q.count;
  assign tail_off  = pos - st_q.tail;
  assign fmt_shift = {st_q.fmt[23:0], byte_i};
  assign is_digit  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  // val * 10 + digit, wide enough to spot overflow past 65535
  assign num_next  = {1'b0, st_q.acc, 3'b000} + {3'b000, st_q.acc, 1'b0} +
                     {16'h0000, 4'(byte_i - CH_ZERO)};

  // Per-byte parse update
  always_comb begin
    upd = st_q;
    if (st_q.count < CountW'(PREFIX_LIMIT)) begin
      upd.count = st_q.count + CountW'(1);
      if (!st_q.err) begin
        unique case (st_q.phase)
          PH_MAGIC: begin
            if (byte_i != MAGIC[pos[2:0]]) begin
              upd.err = 1'b1; upd.first_err = ST_MAGIC;
            end else if (pos >= CountW'(MAGIC_LEN - 1)) begin
              upd.phase = PH_FORMAT;
            end
          end
          PH_FORMAT: begin
            upd.fmt = fmt_shift;
            if (pos >= CountW'(FORMAT_END)) begin
              if (fmt_shift < FMT_MIN || fmt_shift > FMT_MAX) begin
                upd.err = 1'b1; upd.first_err = ST_FORMAT;
              end else begin
                upd.phase = PH_GEN;
                upd.len   = '0;
              end
            end
          end
          PH_GEN: begin
            if (byte_i == CH_NUL) begin
              if (st_q.len == '0) begin
                upd.err = 1'b1; upd.first_err = ST_GEN;
              end else begin
                upd.phase = PH_MAJOR;
                upd.len   = '0;
                upd.have  = 1'b0;
                upd.acc   = '0;
              end
            end else if (st_q.len >= LenW'(MAX_GENERATION_LEN) || !gen_char_ok(byte_i)) begin
              upd.err = 1'b1; upd.first_err = ST_GEN;
            end else begin
              upd.len = st_q.len + LenW'(1);
            end
          end
          PH_TAIL: begin
            if (tail_off < CountW'(SIZE_BYTES)) begin
              upd.size = {st_q.size[55:0], byte_i};
            end else if ((tail_off == CountW'(CBLK_OFFSET) ||
                          tail_off == CountW'(UBLK_OFFSET)) && byte_i[7]) begin
              upd.blk_bad = 1'b1;
            end
          end
          PH_MAJOR, PH_MINOR, PH_PATCH, PH_CHNUM: begin
            // version string: N.N.N<c>N
            if (byte_i == CH_NUL) begin
              if (st_q.len == '0 || st_q.phase != PH_CHNUM || !st_q.have) begin
                upd.err = 1'b1; upd.first_err = ST_VERSION;
              end else begin
                upd.chnum = st_q.acc;
                upd.tail  = pos + CountW'(1);
                upd.phase = PH_TAIL;
              end
            end else if (st_q.len >= LenW'(MAX_VERSION_LEN) ||
                         byte_i < CH_SPACE || byte_i > CH_TILDE) begin
              upd.err = 1'b1; upd.first_err = ST_VERSION;
            end else begin
              upd.len = st_q.len + LenW'(1);
              if (is_digit) begin
                if (num_next > NUM_MAX) begin
                  upd.err = 1'b1; upd.first_err = ST_VERSION;
                end else begin
                  upd.have = 1'b1;
                  upd.acc  = num_next[15:0];
                end
              end else if (!st_q.have) begin
                upd.err = 1'b1; upd.first_err = ST_VERSION;
              end else if (st_q.phase == PH_MAJOR && byte_i == CH_DOT) begin
                upd.major = st_q.acc;
                upd.phase = PH_MINOR;
                upd.have  = 1'b0;
                upd.acc   = '0;
              end else if (st_q.phase == PH_MINOR && byte_i == CH_DOT) begin
                upd.minor = st_q.acc;
                upd.phase = PH_PATCH;
                upd.have  = 1'b0;
                upd.acc   = '0;
              end else if (st_q.phase == PH_PATCH && is_chan_letter(byte_i)) begin
                upd.patch = st_q.acc;
                upd.chan  = chan_code(byte_i);
                upd.phase = PH_CHNUM;
                upd.have  = 1'b0;
                upd.acc   = '0;
              end else begin
                upd.err = 1'b1; upd.first_err = ST_VERSION;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Verdict from the state after this byte
  assign short_prefix = (upd.count < CountW'(MIN_PREFIX)) ||
                        (file_len_i < 64'(upd.count));
  assign tail_short   = (upd.count - upd.tail) < CountW'(TAIL_LEN);
  assign bad_geom     = (upd.size < (64'(upd.tail) + 64'(TAIL_LEN))) ||
                        upd.size[63] || upd.blk_bad;

  always_comb begin
    priority if (short_prefix)        status = ST_SHORT;
    else if (upd.err)                 status = upd.first_err;
    else if (upd.phase == PH_GEN)     status = ST_GEN;
    else if (upd.phase != PH_TAIL)    status = ST_VERSION;
    else if (tail_short)              status = ST_TAIL_SHORT;
    else if (bad_geom)                status = ST_GEOMETRY;
    else                              status = ST_RESOLVED;
  end

  // Result fields, zeroed where the verdict does not reach them
  always_comb begin
    result_o        = '0;
    result_o.status = status;
    if (status != ST_SHORT && status != ST_MAGIC) begin
      result_o.fmt_ver = upd.fmt;
    end
    if (status == ST_RESOLVED || status == ST_GEOMETRY) begin
      result_o.decl_size = upd.size;
    end
    if (status == ST_RESOLVED) begin
      result_o.major_number = upd.major;
      result_o.minor_number = upd.minor;
      result_o.patch_number = upd.patch;
      result_o.channel_code = upd.chan;
      result_o.chan_num     = upd.chnum;
    end
  end

  // Next state: a verdict clears everything for the next prefix
  always_comb begin
    st_d = st_q;
    if (step_i) begin
      st_d = last_i ? PST_RESET : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PST_RESET;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/bundle_header_checker.sv */
// Top level of the bundle header checker: stream ports, size register, staging.
// The block takes one header byte per transaction, one every clock cycle while
// no last byte waits on a blocked verdict, and returns one verdict transaction
// for the byte marked by tlast. An accepted byte is parsed from the input
// register; the parse state registers and, for a last byte, the master-side
// verdict register load together. The parse state registers close the only
// loop, updated once per byte, which sets the rate of one byte per cycle.
// A waiting verdict lets bytes of the next prefix flow in until the last byte
// of that prefix reaches the parse stage; that byte then holds until the
// verdict is taken. Write the file length through cfg_wr_en_i while no prefix
// is in flight; it is kept across verdicts.
`default_nettype none

module bundle_header_checker #(
  parameter int unsigned PREFIX_LIMIT       = bhc_pkg::PREFIX_LIMIT_DEF,
  parameter int unsigned MAX_VERSION_LEN    = bhc_pkg::MAX_VERSION_LEN_DEF,
  parameter int unsigned MAX_GENERATION_LEN = bhc_pkg::MAX_GENERATION_LEN_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // byte stream
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // byte_value[7:0]
  input  wire logic                       s_axis_tlast,  // last_byte
  // verdict stream
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // status[2:0], fmt_ver[34:3], decl_size[98:35],
  // major_number[114:99], minor_number[130:115], patch_number[146:131],
  // channel_code[149:147], chan_num[165:150], zero pad[167:166]
  output      logic [bhc_pkg::OUT_W-1:0] m_axis_tdata,
  // file length register
  input  wire logic                       cfg_wr_en_i,
  input  wire logic [63:0]                cfg_wr_data_i
);
  import bhc_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q;
  result_t     out_res_q;
  result_t     res;
  logic [63:0] file_len_q;
  logic        out_free;
  logic        advance;

  // Staging: the input register moves on unless it holds a last byte whose verdict is blocked
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // file length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= '0;
    end else if (cfg_wr_en_i) begin
      file_len_q <= cfg_wr_data_i;
    end
  end

  bhc_parser #(
    .PREFIX_LIMIT       (PREFIX_LIMIT),
    .MAX_VERSION_LEN    (MAX_VERSION_LEN),
    .MAX_GENERATION_LEN (MAX_GENERATION_LEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .file_len_i  (file_len_q),
    .result_o    (res)
  );

  // Verdict output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && in_last_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W - RES_W){1'b0}}, out_res_q};

endmodule

`default_nettype wire

/* hdl/bhc_checker.sv */
// Port-level assertions for the bundle header checker, bound to the top level.
`default_nettype none

`include "bundle_header_checker_macros.svh"

module bhc_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [bhc_pkg::OUT_W-1:0] m_axis_tdata
);
  import bhc_pkg::*;

  result_t r;
  assign r = m_axis_tdata[RES_W-1:0];

  // a stalled verdict holds
  `BHC_ASSERT_NEXT(a_verdict_hold,
    m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

  // no format word before the format field is judged
  `BHC_ASSERT_NOW(a_fmt_zero,
    m_axis_tvalid && (r.status == ST_SHORT || r.status == ST_MAGIC),
    r.fmt_ver == '0)

  // version and channel only reported for a resolved header
  `BHC_ASSERT_NOW(a_ver_zero,
    m_axis_tvalid && r.status != ST_RESOLVED,
    r.major_number == '0 && r.minor_number == '0 && r.patch_number == '0 &&
    r.channel_code == CHAN_A && r.chan_num == '0)

  // a resolved header has a legal format, channel and size
  `BHC_ASSERT_NOW(a_resolved_ok,
    m_axis_tvalid && r.status == ST_RESOLVED,
    r.fmt_ver >= FMT_MIN && r.fmt_ver <= FMT_MAX && r.channel_code <= CHAN_X &&
    !r.decl_size[63])

endmodule

bind bundle_header_checker bhc_checker u_bhc_checker (.*);

`default_nettype wire

/* test/bundle_header_checker_tb.sv */
// Self-checking testbench for the bundle header checker: byte stream in, verdicts out.
module bundle_header_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bhc_pkg::*;

  // a small byte limit keeps the limit test short
  localparam int unsigned PREFIX_LIMIT = 128;
  localparam int unsigned MAX_VER_LEN  = MAX_VERSION_LEN_DEF;
  localparam int unsigned MAX_GEN_LEN  = MAX_GENERATION_LEN_DEF;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          CFG_SETTLE   = 4;
  localparam string       CHAN_LETTERS = "abcfpx";
  localparam string       GEN_CHARS    =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz._-";

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                cfg_wr_en_i   = 1'b0;
  logic [63:0]         cfg_wr_data_i = '0;

  bundle_header_checker #(
    .PREFIX_LIMIT       (PREFIX_LIMIT),
    .MAX_VERSION_LEN    (MAX_VER_LEN),
    .MAX_GENERATION_LEN (MAX_GEN_LEN)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Verdicts predicted but not yet seen, oldest first
  result_t pending_verdicts[$];
  logic [7:0] prefix_bytes[$];

  int  mismatches    = 0;
  int  verdicts_seen = 0;
  int  bytes_sent    = 0;
  int  verdicts_sent = 0;
  bit  tx_calm       = 1'b0;
  bit  rx_calm       = 1'b0;
  bit  tx_busy       = 1'b0;
  int  rx_wait       = 0;
  int  idle_cycles   = 0;

  // Mirror of the parser state
  logic [63:0] file_len_cur = '0;
  int unsigned byte_cnt;
  phase_e      hp;
  int unsigned fld_len;
  status_e     err_code;
  bit          err_seen;
  logic [31:0] fmt_word;
  int unsigned tail_at;
  logic [63:0] size_acc;
  logic [16:0] num_acc;       // bit 16: current number has a digit
  logic [15:0] ver_num [4];
  chan_e       chan_sel;
  bit          blk_bad;

  function automatic void clear_parser();
    byte_cnt = 0;
    hp       = PH_MAGIC;
    fld_len  = 0;
    err_code = ST_RESOLVED;
    err_seen = 1'b0;
    fmt_word = '0;
    tail_at  = 0;
    size_acc = '0;
    num_acc  = '0;
    ver_num  = '{default: '0};
    chan_sel = CHAN_A;
    blk_bad  = 1'b0;
  endfunction

  function automatic void note_err(status_e code);
    if (!err_seen) begin
      err_seen = 1'b1;
      err_code = code;
    end
  endfunction

  // Advance the parser mirror by one byte; queue a verdict on the last byte
  function automatic void judge_byte(logic [7:0] b, logic last);
    int unsigned pos;
    int unsigned off;
    int unsigned val;
    int          ci;
    bit          have;
    bit          ok;
    status_e     st;
    result_t     v;
    if (byte_cnt < PREFIX_LIMIT) begin
      if (!err_seen) begin
        pos = byte_cnt;
        case (hp)
          PH_MAGIC: begin
            if (b != MAGIC[pos % MAGIC_LEN]) note_err(ST_MAGIC);
            else if (pos >= MAGIC_LEN - 1) hp = PH_FORMAT;
          end
          PH_FORMAT: begin
            fmt_word = {fmt_word[23:0], b};
            if (pos >= FORMAT_END) begin
              if (fmt_word < FMT_MIN || fmt_word > FMT_MAX) note_err(ST_FORMAT);
              else begin
                hp      = PH_GEN;
                fld_len = 0;
              end
            end
          end
          PH_GEN: begin
            ok = (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
                 (b >= "a" && b <= "z") || b == "." || b == "_" || b == "-";
            if (b == CH_NUL) begin
              if (fld_len == 0) note_err(ST_GEN);
              else begin
                hp      = PH_MAJOR;
                fld_len = 0;
                num_acc = '0;
              end
            end else if (fld_len >= MAX_GEN_LEN || !ok) note_err(ST_GEN);
            else fld_len++;
          end
          PH_TAIL: begin
            off = pos - tail_at;
            if (off < SIZE_BYTES) size_acc = {size_acc[55:0], b};
            else if ((off == CBLK_OFFSET || off == UBLK_OFFSET) && b[7]) blk_bad = 1'b1;
          end
          default: begin
            // version string: N.N.N<c>N
            have = num_acc[16];
            val  = num_acc[15:0];
            if (b == CH_NUL) begin
              if (fld_len == 0 || hp != PH_CHNUM || !have) note_err(ST_VERSION);
              else begin
                ver_num[3] = 16'(val);
                tail_at    = pos + 1;
                hp         = PH_TAIL;
              end
            end else if (fld_len >= MAX_VER_LEN || b < CH_SPACE || b > CH_TILDE) begin
              note_err(ST_VERSION);
            end else begin
              fld_len++;
              ci = -1;
              for (int k = 0; k < CHAN_LETTERS.len(); k++)
                if (b == CHAN_LETTERS[k]) ci = k;
              if (b >= CH_ZERO && b <= CH_NINE) begin
                val = val * 10 + (b - CH_ZERO);
                if (val > NUM_MAX) note_err(ST_VERSION);
                else num_acc = {1'b1, 16'(val)};
              end else if (!have) begin
                note_err(ST_VERSION);
              end else if ((hp == PH_MAJOR || hp == PH_MINOR) && b == CH_DOT) begin
                if (hp == PH_MAJOR) begin
                  ver_num[0] = 16'(val);
                  hp         = PH_MINOR;
                end else begin
                  ver_num[1] = 16'(val);
                  hp         = PH_PATCH;
                end
                num_acc = '0;
              end else if (hp == PH_PATCH && ci >= 0) begin
                ver_num[2] = 16'(val);
                chan_sel   = chan_e'(ci[2:0]);
                hp         = PH_CHNUM;
                num_acc    = '0;
              end else begin
                note_err(ST_VERSION);
              end
            end
          end
        endcase
      end
      byte_cnt++;
    end
    if (!last) return;

    // Verdict: short prefix first, then the latched error, then open fields
    if (byte_cnt < MIN_PREFIX || file_len_cur < 64'(byte_cnt)) st = ST_SHORT;
    else if (err_seen) st = err_code;
    else if (hp == PH_GEN) st = ST_GEN;
    else if (hp != PH_TAIL) st = ST_VERSION;
    else if (byte_cnt - tail_at < TAIL_LEN) st = ST_TAIL_SHORT;
    else if (size_acc < 64'(tail_at) + TAIL_LEN || size_acc[63] || blk_bad) st = ST_GEOMETRY;
    else st = ST_RESOLVED;

    v = '0;
    v.status = st;
    if (st != ST_SHORT && st != ST_MAGIC) v.fmt_ver = fmt_word;
    if (st == ST_RESOLVED || st == ST_GEOMETRY) v.decl_size = size_acc;
    if (st == ST_RESOLVED) begin
      v.major_number = ver_num[0];
      v.minor_number = ver_num[1];
      v.patch_number = ver_num[2];
      v.channel_code = chan_sel;
      v.chan_num     = ver_num[3];
    end
    pending_verdicts.insert(pending_verdicts.size(), v);
    clear_parser();
  endfunction

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------

  task automatic release_bus();
    if (tx_busy) begin
      s_axis_tvalid <= 1'b0;
      tx_busy = 1'b0;
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      release_bus();
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    tx_busy = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    judge_byte(b, last);
    bytes_sent++;
    if (last) verdicts_sent++;
  endtask

  task automatic send_prefix();
    foreach (prefix_bytes[k]) send_byte(prefix_bytes[k], k == prefix_bytes.size() - 1);
  endtask

  // Hold the source off until every predicted verdict has arrived
  task automatic wait_drained();
    release_bus();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_file_len(logic [63:0] value);
    wait_drained();
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    file_len_cur = value;
    cfg_wr_en_i   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Header construction
  // ---------------------------------------------------------------------------

  function automatic void add_byte(logic [7:0] b);
    prefix_bytes.insert(prefix_bytes.size(), b);
  endfunction

  function automatic void push_text(string s);
    for (int k = 0; k < s.len(); k++) add_byte(s[k]);
  endfunction

  function automatic void push_be(logic [63:0] value, int n);
    for (int k = n - 1; k >= 0; k--) add_byte(value[8*k +: 8]);
  endfunction

  // With rel set, size is taken as an offset from the smallest legal size
  function automatic void build_header(logic [31:0] fmt, string gen, string ver,
                                       logic [63:0] size, bit rel,
                                       logic [31:0] cblk, logic [31:0] ublk);
    prefix_bytes.delete();
    for (int k = 0; k < MAGIC_LEN; k++) add_byte(MAGIC[k]);
    push_be(fmt, 4);
    push_text(gen);
    add_byte(CH_NUL);
    push_text(ver);
    add_byte(CH_NUL);
    if (rel) size += prefix_bytes.size() + TAIL_LEN;
    push_be(size, 8);
    push_be(cblk, 4);
    push_be(ublk, 4);
    push_be($urandom, 4);
  endfunction

  function automatic string rand_gen_text(int n);
    string s = "";
    for (int k = 0; k < n; k++)
      s = $sformatf("%s%c", s, GEN_CHARS[$urandom_range(0, GEN_CHARS.len() - 1)]);
    return s;
  endfunction

  function automatic string rand_number();
    case ($urandom_range(0, 19))
      16: return "65535";
      17: return $sformatf("%0d", $urandom_range(0, 65535));
      18: return $sformatf("00%0d", $urandom_range(0, 999));
      19: return $sformatf("%0d", $urandom_range(65536, 999999));
      default: return $sformatf("%0d", $urandom_range(0, 99));
    endcase
  endfunction

  // Leading zeros leave the major number unchanged but lengthen the string
  function automatic string zero_pad(string s, int n);
    while (s.len() < n) s = {"0", s};
    return s;
  endfunction

  task automatic make_random_header();
    logic [31:0] fmt;
    logic [63:0] size;
    logic [31:0] cblk;
    logic [31:0] ublk;
    logic [7:0]  chan;
    string       ver;
    int          glen;
    int          pick;
    int          n;
    bit          rel;
    pick = $urandom_range(0, 9);
    if (pick < 8) fmt = 32'($urandom_range(6, 8));
    else if (pick == 8) fmt = 32'($urandom_range(0, 10));
    else fmt = $urandom;

    pick = $urandom_range(0, 19);
    if (pick < 17) glen = $urandom_range(1, 8);
    else if (pick == 17) glen = MAX_GEN_LEN;
    else if (pick == 18) glen = MAX_GEN_LEN + 1;
    else glen = 0;

    chan = ($urandom_range(0, 9) != 0) ? CHAN_LETTERS[$urandom_range(0, 5)]
                                       : 8'($urandom_range(8'h21, 8'h7e));
    ver = $sformatf("%s.%s.%s%c%s", rand_number(), rand_number(), rand_number(), chan,
                    rand_number());
    if ($urandom_range(0, 9) == 0) ver = zero_pad(ver, MAX_VER_LEN - 1 + $urandom_range(0, 2));

    rel = 1'b1;
    case ($urandom_range(0, 9))
      7: size = '1;
      8: begin
        size = 64'h7FFF_FFFF_FFFF_FFFF;
        rel  = 1'b0;
      end
      9: begin
        size = {$urandom, $urandom};
        rel  = 1'b0;
      end
      default: size = 64'($urandom_range(0, 100000));
    endcase
    cblk = ($urandom_range(0, 7) == 0) ? $urandom : ($urandom & 32'h7FFF_FFFF);
    ublk = ($urandom_range(0, 7) == 0) ? $urandom : ($urandom & 32'h7FFF_FFFF);
    build_header(fmt, rand_gen_text(glen), ver, size, rel, cblk, ublk);

    // Occasional damage: a corrupted byte, a cut-off prefix or trailing bytes
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      prefix_bytes[$urandom_range(0, prefix_bytes.size() - 1)] = 8'($urandom);
    end else if (pick < 4) begin
      n = $urandom_range(1, prefix_bytes.size());
      prefix_bytes = prefix_bytes[0:n-1];
    end else if (pick == 4) begin
      repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
    end
  endtask

  task automatic make_noise();
    int n;
    n = $urandom_range(1, 40);
    prefix_bytes.delete();
    repeat (n) add_byte(8'($urandom));
    if ($urandom_range(0, 1) == 1)
      for (int k = 0; k < n && k < MAGIC_LEN; k++) prefix_bytes[k] = MAGIC[k];
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes, every channel letter and each failure kind
  task automatic test_directed();
    write_file_len('1);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    // smallest legal header, declared size exactly at the limit
    build_header(FMT_MIN, "a", "0.0.0a0", '0, 1'b1, '0, '0);
    send_prefix();
    // largest numbers, longest generation string, largest size
    build_header(FMT_MAX, rand_gen_text(MAX_GEN_LEN), "65535.65535.65535x65535",
                 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_prefix();
    for (int k = 0; k < CHAN_LETTERS.len(); k++) begin
      build_header(32'd7, "Gen_1.x-Y", $sformatf("1.2.3%c4", CHAN_LETTERS[k]), 64'd5, 1'b1,
                   32'd1, 32'd2);
      send_prefix();
    end
    // bad magic at the first and the last magic byte
    build_header(FMT_MIN, "a", "1.2.3a4", '0, 1'b1, '0, '0);
    prefix_bytes[0] = 8'h00;
    send_prefix();
    build_header(FMT_MIN, "a", "1.2.3a4", '0, 1'b1, '0, '0);
    prefix_bytes[MAGIC_LEN-1] = 8'hFF;
    send_prefix();
    // format word outside its range
    build_header(32'd5, "a", "1.2.3a4", '0, 1'b1, '0, '0);
    send_prefix();
    build_header(32'd9, "a", "1.2.3a4", '0, 1'b1, '0, '0);
    send_prefix();
    build_header(32'hFFFF_FFFF, "a", "1.2.3a4", '0, 1'b1, '0, '0);
    send_prefix();
    // generation string: empty, too long, bad character
    build_header(FMT_MIN, "", "1.2.3a4", '0, 1'b1, '0, '0);
    send_prefix();
    build_header(FMT_MIN, rand_gen_text(MAX_GEN_LEN + 1), "1.2.3a4", '0, 1'b1, '0, '0);
    send_prefix();
    build_header(FMT_MIN, "ab/c", "1.2.3a4", '0, 1'b1, '0, '0);
    send_prefix();
    // version string: number overflow, bad letter, empty, one too long, longest
    build_header(FMT_MIN, "a", "65536.0.0a0", '0, 1'b1, '0, '0);
    send_prefix();
    build_header(FMT_MIN, "a", "1.2.3d4", '0, 1'b1, '0, '0);
    send_prefix();
    build_header(FMT_MIN, "a", "", '0, 1'b1, '0, '0);
    send_prefix();
    build_header(FMT_MIN, "a", zero_pad("1.2.3a4", MAX_VER_LEN + 1), '0, 1'b1, '0, '0);
    send_prefix();
    build_header(FMT_MIN, "a", zero_pad("1.2.3a4", MAX_VER_LEN), '0, 1'b1, '0, '0);
    send_prefix();
    // one byte under the minimum prefix
    build_header(FMT_MIN, "a", "1.2.3a4", '0, 1'b1, '0, '0);
    prefix_bytes = prefix_bytes[0:MIN_PREFIX-2];
    send_prefix();
    // prefix ends inside the generation string, then inside the version string
    build_header(FMT_MIN, rand_gen_text(30), "1.2.3a4", '0, 1'b1, '0, '0);
    prefix_bytes = prefix_bytes[0:MIN_PREFIX-1];
    send_prefix();
    build_header(FMT_MIN, "g", zero_pad("1.2.3a4", 40), '0, 1'b1, '0, '0);
    prefix_bytes = prefix_bytes[0:MIN_PREFIX+3];
    send_prefix();
    // tail one byte short
    build_header(FMT_MIN, "a", "1.2.3a4", '0, 1'b1, '0, '0);
    void'(prefix_bytes.pop_back());
    send_prefix();
    // geometry: size one under the limit, size with bit 63, each block word flag
    build_header(FMT_MIN, "a", "1.2.3a4", '1, 1'b1, '0, '0);
    send_prefix();
    build_header(FMT_MIN, "a", "1.2.3a4", 64'h8000_0000_0000_0000, 1'b0, '0, '0);
    send_prefix();
    build_header(FMT_MIN, "a", "1.2.3a4", '0, 1'b1, 32'h8000_0000, '0);
    send_prefix();
    build_header(FMT_MIN, "a", "1.2.3a4", '0, 1'b1, '0, 32'h8000_0000);
    send_prefix();
    // bytes after the tail, running past the byte limit
    build_header(FMT_MIN, "a", "1.2.3a4", 64'd999, 1'b1, '0, '0);
    repeat (PREFIX_LIMIT + 8) add_byte(8'($urandom));
    send_prefix();
  endtask

  // File length of zero, exactly the prefix length, and one below it
  task automatic test_file_len_edges();
    int len;
    build_header(FMT_MAX, "edge", "3.1.4p1", 64'd7, 1'b1, '0, '0);
    len = prefix_bytes.size();
    write_file_len('0);
    send_prefix();
    write_file_len(64'(len));
    send_prefix();
    write_file_len(64'(len - 1));
    send_prefix();
  endtask

  task automatic test_random(logic [63:0] fsize, int n_bytes, int n_verdicts);
    int byte_goal;
    int verdict_goal;
    write_file_len(fsize);
    byte_goal    = bytes_sent + n_bytes;
    verdict_goal = verdicts_sent + n_verdicts;
    while (bytes_sent < byte_goal || verdicts_sent < verdict_goal) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_calm = ($urandom_range(0, 2) == 0);
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 4) == 0) make_noise();
      else make_random_header();
      send_prefix();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Verdict sink and checker
  // ---------------------------------------------------------------------------

  result_t got_v;
  result_t want_v;

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("verdict %0d: %s expected 0x%0h, got 0x%0h", verdicts_seen, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_v = result_t'(m_axis_tdata[RES_W-1:0]);
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict %0d: unexpected transaction, status 0x%0h",
                     verdicts_seen, got_v.status);
        end else begin
          want_v = pending_verdicts.pop_front();
          cmp_field("status", want_v.status, got_v.status);
          cmp_field("fmt_ver", want_v.fmt_ver, got_v.fmt_ver);
          cmp_field("decl_size", want_v.decl_size, got_v.decl_size);
          cmp_field("major_number", want_v.major_number, got_v.major_number);
          cmp_field("minor_number", want_v.minor_number, got_v.minor_number);
          cmp_field("patch_number", want_v.patch_number, got_v.patch_number);
          cmp_field("channel_code", want_v.channel_code, got_v.channel_code);
          cmp_field("chan_num", want_v.chan_num, got_v.chan_num);
        end
        verdicts_seen++;
        // draw the stall before the next verdict
        rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
        if (rx_wait != 0) m_axis_tready <= 1'b0;
      end else if (!m_axis_tready) begin
        if (rx_wait <= 1) m_axis_tready <= 1'b1;
        else rx_wait = rx_wait - 1;
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_parser();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_file_len_edges();
    test_random('1, 120, 4);
    test_random({$urandom, $urandom}, 60, 3);
    test_random(64'($urandom_range(32, 120)), 60, 3);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
